/* design/sfcd_pkg.sv */
// Shared types, constants and the CRC-16/MODBUS byte update for the sensor frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package sfcd_pkg;

  // CRC-16/MODBUS: reflected, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Sign-magnitude temperature word
  localparam logic [15:0] SIGN_BIT = 16'h8000;
  localparam logic [15:0] MAG_MASK = 16'h7FFF;

  // Byte positions within the eight-byte frame
  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] POS_HUM_HI  = 3'd2;
  localparam logic [POS_W-1:0] POS_HUM_LO  = 3'd3;
  localparam logic [POS_W-1:0] POS_TEMP_HI = 3'd4;
  localparam logic [POS_W-1:0] POS_TEMP_LO = 3'd5;
  localparam logic [POS_W-1:0] POS_CRC_LO  = 3'd6;
  localparam logic [POS_W-1:0] POS_CRC_HI  = 3'd7;
  // bytes below this position are covered by the CRC
  localparam logic [POS_W-1:0] PAYLOAD_LEN = 3'd6;

  // Frame status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_CRC_FAIL = 1'b1;

  // Input word: one response byte
  typedef struct packed {
    logic [7:0] resp_byte;
    logic       frame_start;
  } sfcd_in_t;

  // Output word: one decoded frame
  typedef struct packed {
    logic        [15:0] humidity_raw;
    logic signed [15:0] temperature_val;
    logic               frame_status;
  } sfcd_out_t;

  // Fold one byte into the CRC, LSB first
  function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc_in,
                                                input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // Sign-magnitude to two's complement; negative zero gives zero
  function automatic logic [15:0] sm_to_twos(input logic [15:0] sm);
    logic [15:0] mag;
    mag = sm & MAG_MASK;
    if ((sm & SIGN_BIT) != 16'h0000) begin
      return (~mag) + 16'd1;
    end
    return mag;
  endfunction

endpackage

`default_nettype wire

/* design/sensor_frame_crc_decoder_core.sv */
// Top level of the sensor frame decoder: byte input register, frame decode and result register.
// Sensor frame decoder with CRC-16/MODBUS check.
// Input channel (src_*): one response byte per word, with a start flag that
// forces the byte to be taken as byte 0 of a new frame. Output channel (dst_*):
// one word per complete eight-byte frame carrying humidity (bytes 2..3,
// big-endian), temperature in two's complement (bytes 4..5, sign-magnitude)
// and a status of CRC ok or CRC mismatch against bytes 6..7 (little-endian).
// Bytes 0..5 feed the CRC; bytes of a frame cut short by a new start produce
// nothing.
// Throughput: one byte per cycle, unless a byte 7 waits on a stalled dst.
// The CRC byte update is eight unrolled shift/xor steps between the input
// register and the frame state registers. A byte leaves the input register
// into the frame state registers; for byte 7 the result register is written too.
// Stall: while dst is stalled with a result pending, bytes other than a final
// byte 7 keep flowing; a byte 7 waits in the input register and src_stall is
// raised until the pending result is taken.
// Reset (rst, synchronous): byte count to 0, CRC to 0xFFFF, holds to 0, both
// registers empty.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_crc_decoder_core (
  input  wire                clk,
  input  wire                rst,
  input  wire                src_valid,
  output logic               src_stall,
  input  wire sfcd_pkg::sfcd_in_t src_word,
  output logic               dst_valid,
  input  wire                dst_stall,
  output sfcd_pkg::sfcd_out_t dst_word
);

  // Input register
  logic                 s1_valid;
  sfcd_pkg::sfcd_in_t   s1_word;

  // Frame state
  logic [sfcd_pkg::POS_W-1:0] byte_count;
  logic [15:0]                running_crc;
  logic [15:0]                humidity_hold;
  logic [15:0]                temperature_hold;
  logic [7:0]                 crc_low_hold;

  logic [sfcd_pkg::POS_W-1:0] byte_count_next;
  logic [15:0]                running_crc_next;
  logic [15:0]                humidity_hold_next;
  logic [15:0]                temperature_hold_next;
  logic [7:0]                 crc_low_hold_next;

  logic [sfcd_pkg::POS_W-1:0] pos;
  logic [15:0]                crc_base;
  logic [15:0]                crc_folded;
  logic [15:0]                check;
  logic                       s1_emits;
  logic                       s1_advance;
  logic                       src_take;
  logic                       dst_free;
  sfcd_pkg::sfcd_out_t        result;

  // Position and CRC seed, honouring the start flag
  always_comb begin
    if (s1_word.frame_start) begin
      pos      = '0;
      crc_base = sfcd_pkg::CRC_INIT;
    end else begin
      pos      = byte_count;
      crc_base = running_crc;
    end
  end

  assign crc_folded = sfcd_pkg::crc_fold_byte(crc_base, s1_word.resp_byte);
  assign check      = {s1_word.resp_byte, crc_low_hold};

  // Handshake: only a final byte needs room in the result register
  assign s1_emits   = (pos == sfcd_pkg::POS_CRC_HI);
  assign dst_free   = !dst_valid || !dst_stall;
  assign s1_advance = s1_valid && (!s1_emits || dst_free);
  assign src_stall  = s1_valid && !s1_advance;
  assign src_take   = src_valid && !src_stall;

  // Frame state update for the byte in the input register
  always_comb begin
    byte_count_next       = pos + 3'd1;
    running_crc_next      = crc_base;
    humidity_hold_next    = humidity_hold;
    temperature_hold_next = temperature_hold;
    crc_low_hold_next     = crc_low_hold;
    if (pos < sfcd_pkg::PAYLOAD_LEN) begin
      running_crc_next = crc_folded;
    end
    unique case (pos)
      sfcd_pkg::POS_HUM_HI:  humidity_hold_next[15:8]    = s1_word.resp_byte;
      sfcd_pkg::POS_HUM_LO:  humidity_hold_next[7:0]     = s1_word.resp_byte;
      sfcd_pkg::POS_TEMP_HI: temperature_hold_next[15:8] = s1_word.resp_byte;
      sfcd_pkg::POS_TEMP_LO: temperature_hold_next[7:0]  = s1_word.resp_byte;
      sfcd_pkg::POS_CRC_LO:  crc_low_hold_next           = s1_word.resp_byte;
      sfcd_pkg::POS_CRC_HI:  running_crc_next            = sfcd_pkg::CRC_INIT;
      default: begin
      end
    endcase
  end

  // Result word for a completed frame
  always_comb begin
    result.humidity_raw    = humidity_hold;
    result.temperature_val = $signed(sfcd_pkg::sm_to_twos(temperature_hold));
    result.frame_status    = (crc_base != check) ? sfcd_pkg::STATUS_CRC_FAIL
                                                 : sfcd_pkg::STATUS_OK;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      s1_word <= src_word;
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      running_crc      <= sfcd_pkg::CRC_INIT;
      humidity_hold    <= '0;
      temperature_hold <= '0;
      crc_low_hold     <= '0;
    end else if (s1_advance) begin
      byte_count       <= byte_count_next;
      running_crc      <= running_crc_next;
      humidity_hold    <= humidity_hold_next;
      temperature_hold <= temperature_hold_next;
      crc_low_hold     <= crc_low_hold_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (s1_advance && s1_emits) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_emits) begin
      dst_word <= result;
    end
  end

endmodule

`default_nettype wire
